@@ design/rbb_pkg.sv @@
// Package for the region border blur block: constants, types and the reciprocal table.
// No dependencies.
package rbb_pkg;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int LABEL_BITS_DEF = 16;
    localparam int MAX_HEIGHT     = 4096;
    localparam int W_CENTRE       = 384;
    localparam int W_ORTHO        = 256;
    localparam int W_DIAG         = 181;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // One classified job handed from the front part to the back part.
    typedef struct packed {
        logic        emit;
        logic [11:0] ox;
        logic [12:0] oy;
        logic        last;
    } t_job;

    // Back part sequence: read the window, test and scale, present.
    typedef enum logic [2:0] {S_IDLE, S_READ, S_SCALE, S_MUL, S_OUT} t_bstate;

    function automatic logic [15:0] f_recip(input logic [3:0] cells);
        logic [15:0] r;
        begin
            case (cells)
                4'd4:    r = 16'd15578;
                4'd6:    r = 16'd11081;
                4'd9:    r = 16'd7869;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction
endpackage

@@ design/rbb_if.sv @@
// Valid/ready channel interfaces for the region border blur block.
// Depends on nothing.
interface rbb_in_if;
    logic          valid;
    logic          ready;
    logic          operation;
    logic [7:0]    red_in;
    logic [7:0]    green_in;
    logic [7:0]    blue_in;
    logic [15:0]   region_label;
    modport source(output valid, operation, red_in, green_in, blue_in, region_label,
                   input ready);
    modport sink(input valid, operation, red_in, green_in, blue_in, region_label,
                 output ready);
endinterface

interface rbb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       border_flag;
    logic       frame_last;
    modport source(output valid, red_out, green_out, blue_out, border_flag, frame_last,
                   input ready);
    modport sink(input valid, red_out, green_out, blue_out, border_flag, frame_last,
                 output ready);
endinterface

interface rbb_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [12:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ design/region_border_blur_3x3.sv @@
// Top level of the region border blur block: front, line stores and back part.
// Depends on rbb_pkg, the channel interfaces, rbb_front and rbb_back.
//
// Use: pixels arrive on in_ch in row-major order, one per transfer, with an
// RGB colour and a region label; drain ticks (operation = 1) after the last
// pixel of a frame push out the trailing frame_width+1 results. Results leave
// on out_ch; each is the centre pixel, or the weighted 3x3 mean when the
// window holds a different label, with border_flag and frame_last.
// cfg_ch writes frame_width (index 0) or frame_height (index 1) and restarts
// the frame; write only while the block is idle.
// Steps: with the back part free, it takes the job, reads the nine window
// cells over the single registered read port, does the border test and first
// product, then scales the channels on one multiplier and offers the result.
// The back part takes no new job until its result has been taken.
// Fill items and early drains are handled in the front part and make no job; a
// two-entry job queue lets the front keep taking items while the back works.
// The first item of a frame waits until all jobs of the last frame are done.
// Reset returns to the default size and frame start; line stores need no clear.
// A stalled receiver holds the result and fills the queue, then in_ch.ready drops.
module region_border_blur_3x3 #(
    parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
    parameter int LABEL_BITS = rbb_pkg::LABEL_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbb_in_if.sink     in_ch,
    rbb_cfg_if.sink    cfg_ch,
    rbb_out_if.source  out_ch
);
    localparam int AW = $clog2(MAX_WIDTH);

    logic                  job_valid, job_ready, wr_en, busy;
    rbb_pkg::t_job         job;
    logic [11:0]           width;
    logic [12:0]           height;
    logic [1:0]            wr_row, rd_row;
    logic [AW-1:0]         wr_col, rd_col;
    logic [23:0]           wr_rgb, r_rd_rgb;
    logic [LABEL_BITS-1:0] wr_lab, r_rd_lab;

    // four row stores, colour and label side by side
    logic [23:0]           r_rgb_mem [4*(2**AW)];
    logic [LABEL_BITS-1:0] r_lab_mem [4*(2**AW)];

    rbb_front #(.MAX_WIDTH(MAX_WIDTH), .LABEL_BITS(LABEL_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch),
        .i_job_ready(job_ready), .i_back_busy(busy), .o_job_valid(job_valid),
        .o_job(job), .o_width(width), .o_height(height), .o_wr_en(wr_en),
        .o_wr_row(wr_row), .o_wr_col(wr_col), .o_wr_rgb(wr_rgb), .o_wr_lab(wr_lab)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rgb_mem[{wr_row, wr_col}] <= wr_rgb;
            r_lab_mem[{wr_row, wr_col}] <= wr_lab;
        end
        r_rd_rgb <= r_rgb_mem[{rd_row, rd_col}];
        r_rd_lab <= r_lab_mem[{rd_row, rd_col}];
    end

    rbb_back #(.MAX_WIDTH(MAX_WIDTH), .LABEL_BITS(LABEL_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid),
        .o_job_ready(job_ready), .i_job(job), .i_width(width), .i_height(height),
        .o_rd_row(rd_row), .o_rd_col(rd_col), .i_rd_rgb(r_rd_rgb),
        .i_rd_lab(r_rd_lab), .o_busy(busy), .out_ch(out_ch)
    );

    // A result is never shown while the back part sits idle.
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> busy) else $error("result without a job");
    // A result held off by the receiver stays offered.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    // A taken job that asks for a result keeps the back part busy.
    a_job_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid && job_ready |=> busy || !$past(job.emit)) else $error("job lost");
endmodule

@@ design/rbb_back.sv @@
// Back part: walks the 3x3 window of one job over nine memory reads, then
// accumulates, scales and outputs. Depends on rbb_pkg.
module rbb_back #(
    parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
    parameter int LABEL_BITS = rbb_pkg::LABEL_BITS_DEF,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  rbb_pkg::t_job         i_job,
    input  logic [11:0]           i_width,
    input  logic [12:0]           i_height,
    // memory read port
    output logic [1:0]            o_rd_row,
    output logic [AW-1:0]         o_rd_col,
    input  logic [23:0]           i_rd_rgb,
    input  logic [LABEL_BITS-1:0] i_rd_lab,
    output logic                  o_busy,
    rbb_out_if.source             out_ch
);
    rbb_pkg::t_bstate r_state, n_state;

    rbb_pkg::t_job r_job;
    logic [3:0]  r_k;        // window cell being addressed
    logic [3:0]  r_kd;       // cell whose data returns this cycle
    logic        r_dv;       // read data valid
    logic        r_din;      // returned cell in frame
    logic [19:0] r_acc [3];
    logic [3:0]  r_cells;
    logic [23:0] r_crgb;
    logic [LABEL_BITS-1:0] r_clab;
    logic [LABEL_BITS-1:0] r_labs [9];
    logic [8:0]  r_lin;
    logic [1:0]  r_ch;
    logic [35:0] r_prod;
    logic [7:0]  r_res [3];
    logic        r_border;

    logic signed [14:0] y_s;
    logic signed [13:0] x_s;
    logic               in_frame;
    logic [8:0]         wt;
    logic [1:0]         ky;
    logic [1:0]         kx;
    logic               border_any;

    always_comb begin
        // row and column offset of the addressed cell
        case (r_k)
            4'd0: begin ky = 2'd0; kx = 2'd0; end
            4'd1: begin ky = 2'd0; kx = 2'd1; end
            4'd2: begin ky = 2'd0; kx = 2'd2; end
            4'd3: begin ky = 2'd1; kx = 2'd0; end
            4'd4: begin ky = 2'd1; kx = 2'd1; end
            4'd5: begin ky = 2'd1; kx = 2'd2; end
            4'd6: begin ky = 2'd2; kx = 2'd0; end
            4'd7: begin ky = 2'd2; kx = 2'd1; end
            default: begin ky = 2'd2; kx = 2'd2; end
        endcase
        y_s = $signed({2'b00, r_job.oy}) + $signed({13'd0, ky}) - 15'sd1;
        x_s = $signed({2'b00, r_job.ox}) + $signed({12'd0, kx}) - 14'sd1;
        in_frame = (y_s >= 0) && (x_s >= 0) && (y_s < $signed({2'b00, i_height}))
                   && (x_s < $signed({2'b00, i_width}));
        o_rd_row = y_s[1:0];
        o_rd_col = x_s[AW-1:0];
        if (r_kd == 4'd4) wt = 9'(rbb_pkg::W_CENTRE);
        else if (r_kd == 4'd1 || r_kd == 4'd3 || r_kd == 4'd5 || r_kd == 4'd7)
            wt = 9'(rbb_pkg::W_ORTHO);
        else wt = 9'(rbb_pkg::W_DIAG);
    end

    always_comb begin
        border_any = 1'b0;
        for (int i = 0; i < 9; i++)
            if (r_lin[i] && r_labs[i] != r_clab) border_any = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbb_pkg::S_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= (r_state == rbb_pkg::S_READ) && (r_k != 4'd9);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rbb_pkg::S_IDLE:
                if (i_job_valid) n_state = i_job.emit ? rbb_pkg::S_READ : rbb_pkg::S_IDLE;
            rbb_pkg::S_READ:  if (r_k == 4'd9 && !r_dv) n_state = rbb_pkg::S_SCALE;
            rbb_pkg::S_SCALE: n_state = rbb_pkg::S_MUL;
            rbb_pkg::S_MUL:   if (r_ch == 2'd2) n_state = rbb_pkg::S_OUT;
            rbb_pkg::S_OUT:   if (out_ch.ready) n_state = rbb_pkg::S_IDLE;
            default: n_state = rbb_pkg::S_IDLE;
        endcase
    end

    assign o_job_ready = (r_state == rbb_pkg::S_IDLE);
    assign o_busy      = (r_state != rbb_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (r_state == rbb_pkg::S_IDLE && i_job_valid) begin
            r_job   <= i_job;
            r_k     <= 4'd0;
            r_cells <= 4'd0;
            r_lin   <= 9'd0;
            for (int c = 0; c < 3; c++) r_acc[c] <= 20'd0;
        end
        if (r_state == rbb_pkg::S_READ) begin
            if (r_k != 4'd9) r_k <= r_k + 4'd1;
            r_kd  <= r_k;
            r_din <= in_frame;
            if (r_dv && r_din) begin
                r_acc[0] <= r_acc[0] + 20'(wt) * 20'(i_rd_rgb[23:16]);
                r_acc[1] <= r_acc[1] + 20'(wt) * 20'(i_rd_rgb[15:8]);
                r_acc[2] <= r_acc[2] + 20'(wt) * 20'(i_rd_rgb[7:0]);
                r_cells  <= r_cells + 4'd1;
                r_labs[r_kd] <= i_rd_lab;
                r_lin[r_kd]  <= 1'b1;
                if (r_kd == 4'd4) begin
                    r_crgb <= i_rd_rgb;
                    r_clab <= i_rd_lab;
                end
            end
        end
        if (r_state == rbb_pkg::S_SCALE) begin
            r_border <= border_any;
            r_ch     <= 2'd0;
            r_prod   <= 36'(r_acc[0]) * 36'(rbb_pkg::f_recip(r_cells));
        end
        if (r_state == rbb_pkg::S_MUL) begin
            r_res[r_ch] <= (r_prod[35:24] > 12'd255) ? 8'd255 : r_prod[31:24];
            r_ch        <= r_ch + 2'd1;
            if (r_ch != 2'd2)
                r_prod <= 36'(r_acc[r_ch + 2'd1]) * 36'(rbb_pkg::f_recip(r_cells));
        end
    end

    assign out_ch.valid       = (r_state == rbb_pkg::S_OUT);
    assign out_ch.red_out     = r_border ? r_res[0] : r_crgb[23:16];
    assign out_ch.green_out   = r_border ? r_res[1] : r_crgb[15:8];
    assign out_ch.blue_out    = r_border ? r_res[2] : r_crgb[7:0];
    assign out_ch.border_flag = r_border;
    assign out_ch.frame_last  = r_job.last;
endmodule

@@ design/rbb_front.sv @@
// Front part: accepts items and configuration, tracks the stream position,
// writes the line stores and queues jobs for the back part. Depends on rbb_pkg.
module rbb_front #(
    parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
    parameter int LABEL_BITS = rbb_pkg::LABEL_BITS_DEF,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rbb_in_if.sink                in_ch,
    rbb_cfg_if.sink               cfg_ch,
    input  logic                  i_job_ready,
    input  logic                  i_back_busy,
    output logic                  o_job_valid,
    output rbb_pkg::t_job         o_job,
    output logic [11:0]           o_width,
    output logic [12:0]           o_height,
    output logic                  o_wr_en,
    output logic [1:0]            o_wr_row,
    output logic [AW-1:0]         o_wr_col,
    output logic [23:0]           o_wr_rgb,
    output logic [LABEL_BITS-1:0] o_wr_lab
);
    logic [11:0] r_width;
    logic [12:0] r_height;
    logic [11:0] r_col;
    logic [12:0] r_row;
    logic [24:0] r_pos;
    // two-entry job queue
    rbb_pkg::t_job r_q [2];
    logic [1:0]    r_cnt;
    logic          r_rp;
    logic          r_wp;

    logic [24:0] total, endp;
    logic        in_frame_px, do_emit, push, pop, acc;
    rbb_pkg::t_job job_new;
    logic [11:0] cfg_w;
    logic [12:0] cfg_h;

    assign cfg_ch.ready = 1'b1;
    // hold the first item of a frame until the last frame's jobs are done
    assign in_ch.ready  = (r_cnt != 2'd2)
                          && !(r_pos == 25'd0 && (r_cnt != 2'd0 || i_back_busy));
    assign acc          = in_ch.valid && in_ch.ready;

    always_comb begin
        total       = 25'(r_height) * 25'(r_width);
        endp        = total + 25'(r_width) + 25'd1;
        in_frame_px = (r_pos < total);
        do_emit     = (r_pos >= 25'(r_width) + 25'd1);
        if (r_col != 12'd0) begin
            job_new.ox = r_col - 12'd1;
            job_new.oy = r_row - 13'd1;
        end else begin
            job_new.ox = r_width - 12'd1;
            job_new.oy = r_row - 13'd2;
        end
        job_new.emit = 1'b1;
        job_new.last = (r_pos + 25'd1 == endp);
        // drain tick before frame end does nothing
        push = acc && !(in_frame_px && in_ch.operation) && do_emit;
        pop  = o_job_valid && i_job_ready;
        // clamp the written sizes
        cfg_w = cfg_ch.data[11:0];
        if (cfg_w < 12'd2) cfg_w = 12'd2;
        if (int'(cfg_w) > MAX_WIDTH) cfg_w = 12'(MAX_WIDTH);
        cfg_h = cfg_ch.data;
        if (cfg_h < 13'd2) cfg_h = 13'd2;
        if (cfg_h > 13'(rbb_pkg::MAX_HEIGHT)) cfg_h = 13'(rbb_pkg::MAX_HEIGHT);
    end

    assign o_wr_en  = acc && in_frame_px && !in_ch.operation;
    assign o_wr_row = r_row[1:0];
    assign o_wr_col = AW'(r_col);
    assign o_wr_rgb = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
    assign o_wr_lab = LABEL_BITS'(in_ch.region_label);

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign o_width     = r_width;
    assign o_height    = r_height;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= job_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'((MAX_WIDTH < 2048) ? MAX_WIDTH : 2048);
            r_height <= 13'd480;
            r_col    <= 12'd0;
            r_row    <= 13'd0;
            r_pos    <= 25'd0;
            r_cnt    <= 2'd0;
            r_rp     <= 1'b0;
            r_wp     <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            if (cfg_ch.valid) begin
                if (cfg_ch.index == rbb_pkg::REG_WIDTH) begin
                    r_width <= cfg_w;
                end else begin
                    r_height <= cfg_h;
                end
                r_col <= 12'd0;
                r_row <= 13'd0;
                r_pos <= 25'd0;
            end else if (acc && !(in_frame_px && in_ch.operation)) begin
                if (r_pos + 25'd1 >= endp) begin
                    r_col <= 12'd0;
                    r_row <= 13'd0;
                    r_pos <= 25'd0;
                end else begin
                    r_pos <= r_pos + 25'd1;
                    if (r_col + 12'd1 >= r_width) begin
                        r_col <= 12'd0;
                        r_row <= r_row + 13'd1;
                    end else begin
                        r_col <= r_col + 12'd1;
                    end
                end
            end
        end
    end
endmodule
